// ----- rtl/core/lhist_pkg.sv -----
// ----------------------------------------------------------------------------
// lhist_pkg
// Shared constants, types and helper functions of the luminance histogram.
// ----------------------------------------------------------------------------
package lhist_pkg;

	localparam int BINS        = 256;
	localparam int COUNT_WIDTH = 32;
	localparam int BIN_W       = (BINS > 1) ? $clog2(BINS) : 1;

	localparam int CH_W    = 8;
	localparam int COEF_W  = 16;
	localparam int PROD_W  = CH_W + COEF_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int LUMA_W  = 8;
	localparam int SCALE_W = LUMA_W + 9;
	localparam int BSEL_W  = 10;
	localparam int IDX_W   = 8;
	localparam int IDXC_W  = IDX_W + 1;
	localparam int CMD_W   = 2;
	localparam int OUT_W   = 32;

	localparam int S_FIELDS_W = CMD_W + 3 * CH_W + IDX_W;
	localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_DATA_W   = ((OUT_W + 7) / 8) * 8;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	localparam logic [COEF_W-1:0] W_RED   = 16'd13933;
	localparam logic [COEF_W-1:0] W_GREEN = 16'd46871;
	localparam logic [COEF_W-1:0] W_BLUE  = 16'd4732;

	localparam logic [63:0] OUT_MAX = 64'h0000_0000_FFFF_FFFF;

	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_READ,
		OP_READ_ZERO,
		OP_CLEAR
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [BIN_W-1:0]  bin;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_word_t;

	function automatic logic [BIN_W-1:0] bin_of(input logic [LUMA_W-1:0] lum);
		logic [SCALE_W-1:0] prod;
		logic [BSEL_W-1:0]  b;
		prod = SCALE_W'(lum) * SCALE_W'(BINS);
		b = BSEL_W'(prod >> LUMA_W);
		if (b >= BSEL_W'(BINS)) begin
			b = BSEL_W'(BINS - 1);
		end
		return BIN_W'(b);
	endfunction

	function automatic logic [OUT_W-1:0] out_sat(input logic [COUNT_WIDTH-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		if (w > OUT_MAX) begin
			return '1;
		end
		return w[OUT_W-1:0];
	endfunction

endpackage

// ----- rtl/core/lhist_ram.sv -----
// ----------------------------------------------------------------------------
// lhist_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lhist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/lhist_front.sv -----
// ----------------------------------------------------------------------------
// lhist_front
// Accepts command words, decodes them and computes the luma bin of a pixel.
// ----------------------------------------------------------------------------
module lhist_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// cmd, red, green, blue, bin_index
	input  logic [lhist_pkg::S_DATA_W-1:0]   s_axis_tdata,
	output lhist_pkg::q_word_t               push,
	input  logic                             q_full
);
	import lhist_pkg::*;

	logic [CMD_W-1:0]  cmd;
	logic [CH_W-1:0]   red;
	logic [CH_W-1:0]   green;
	logic [CH_W-1:0]   blue;
	logic [IDX_W-1:0]  bin_index;
	logic              accept;
	logic              take;
	op_kind_t          kind_in;

	logic              v_s1;
	op_kind_t          kind_s1;
	logic [BIN_W-1:0]  bin_s1;
	logic [PROD_W-1:0] prod_r_s1;
	logic [PROD_W-1:0] prod_g_s1;
	logic [PROD_W-1:0] prod_b_s1;

	logic [SUM_W-1:0]  sum;
	logic [LUMA_W-1:0] lum;

	assign cmd       = s_axis_tdata[CMD_W-1:0];
	assign red       = s_axis_tdata[CMD_W +: CH_W];
	assign green     = s_axis_tdata[CMD_W + CH_W +: CH_W];
	assign blue      = s_axis_tdata[CMD_W + 2 * CH_W +: CH_W];
	assign bin_index = s_axis_tdata[CMD_W + 3 * CH_W +: IDX_W];

	assign s_axis_tready = !v_s1 || !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		take    = 1'b1;
		kind_in = OP_ADD;
		case (cmd)
			CMD_ADD: begin
				kind_in = OP_ADD;
			end
			CMD_READ: begin
				kind_in = (IDXC_W'(bin_index) < IDXC_W'(BINS)) ? OP_READ : OP_READ_ZERO;
			end
			CMD_CLEAR: begin
				kind_in = OP_CLEAR;
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept && take) begin
			v_s1 <= 1'b1;
		end else if (push.valid) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && take) begin
			kind_s1   <= kind_in;
			bin_s1    <= BIN_W'(bin_index);
			prod_r_s1 <= PROD_W'(W_RED) * PROD_W'(red);
			prod_g_s1 <= PROD_W'(W_GREEN) * PROD_W'(green);
			prod_b_s1 <= PROD_W'(W_BLUE) * PROD_W'(blue);
		end
	end

	assign sum = SUM_W'(prod_r_s1) + SUM_W'(prod_g_s1) + SUM_W'(prod_b_s1);
	assign lum = sum[COEF_W +: LUMA_W];

	assign push.valid      = v_s1 && !q_full;
	assign push.entry.kind = kind_s1;
	assign push.entry.bin  = (kind_s1 == OP_ADD) ? bin_of(lum) : bin_s1;

endmodule

// ----- rtl/core/lhist_fifo.sv -----
// ----------------------------------------------------------------------------
// lhist_fifo
// Short queue of decoded operations between the front and the back.
// ----------------------------------------------------------------------------
module lhist_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  lhist_pkg::q_word_t push,
	output logic               full,
	input  logic               pop,
	output lhist_pkg::q_word_t head
);
	import lhist_pkg::*;

	q_entry_t              mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_pop;

	assign full       = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push.valid && !do_pop) begin
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			end else if (!push.valid && do_pop) begin
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

endmodule

// ----- rtl/core/lhist_back.sv -----
// ----------------------------------------------------------------------------
// lhist_back
// Executes queued operations on the bin counts and drives the result word.
// ----------------------------------------------------------------------------
module lhist_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lhist_pkg::q_word_t               head,
	output logic                             pop,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// bin_count
	output logic [lhist_pkg::M_DATA_W-1:0]   m_axis_tdata
);
	import lhist_pkg::*;

	logic                   v_s2;
	op_kind_t               kind_s2;
	logic [BIN_W-1:0]       bin_s2;
	logic [BINS-1:0]        valid_q;

	logic                   fwd_v_q;
	logic [BIN_W-1:0]       fwd_bin_q;
	logic [COUNT_WIDTH-1:0] fwd_cnt_q;

	logic                   out_v_q;
	logic [OUT_W-1:0]       out_data_q;

	logic [COUNT_WIDTH-1:0] rd_data;
	logic [COUNT_WIDTH-1:0] mem_cnt;
	logic [COUNT_WIDTH-1:0] cur;
	logic [COUNT_WIDTH-1:0] inc;
	logic                   is_read;
	logic                   out_free;
	logic                   adv;
	logic                   wr_en;
	logic                   out_load;

	lhist_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(BINS)
	) u_counts (
		.clk   (clk),
		.we    (wr_en),
		.waddr (bin_s2),
		.wdata (inc),
		.re    (pop),
		.raddr (head.entry.bin),
		.rdata (rd_data)
	);

	// last write lands on the same edge as this read, so take it from the bypass
	assign mem_cnt  = (fwd_v_q && (fwd_bin_q == bin_s2)) ? fwd_cnt_q : rd_data;
	assign cur      = valid_q[bin_s2] ? mem_cnt : '0;
	assign inc      = (&cur) ? cur : cur + COUNT_WIDTH'(1);

	assign is_read  = (kind_s2 == OP_READ) || (kind_s2 == OP_READ_ZERO);
	assign out_free = !out_v_q || m_axis_tready;
	assign adv      = !v_s2 || !is_read || out_free;
	assign pop      = head.valid && adv;
	assign wr_en    = v_s2 && (kind_s2 == OP_ADD);
	assign out_load = v_s2 && is_read && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			valid_q <= '0;
			fwd_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv) begin
				v_s2 <= pop;
			end
			if (v_s2 && (kind_s2 == OP_CLEAR)) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[bin_s2] <= 1'b1;
			end
			if (pop) begin
				fwd_v_q <= wr_en;
			end else if (wr_en) begin
				fwd_v_q <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s2   <= head.entry.kind;
			bin_s2    <= head.entry.bin;
			fwd_bin_q <= bin_s2;
			fwd_cnt_q <= inc;
		end
		if (out_load) begin
			out_data_q <= (kind_s2 == OP_READ) ? out_sat(cur) : '0;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = M_DATA_W'(out_data_q);

endmodule

// ----- rtl/core/luminance_histogram.sv -----
// ----------------------------------------------------------------------------
// luminance_histogram
// Histogram of BT.709 luma over 8-bit RGB pixels, with read and clear words.
// ----------------------------------------------------------------------------
// One command word is accepted per clock when the result side is not backed
// up. For a pixel word, the front takes the three weighted products in one
// stage and forms the bin as it enters the four-entry queue, and the back does
// the count read-modify-write through the counts RAM with a bypass of the
// previous write, so back-to-back hits on one bin keep pace. A read word
// passes the front stage, the queue and the back stage before its count is
// registered in the result register. A clear word drops the per-bin valid
// flags and no clearing pass over the RAM is needed, neither after reset.
// Counts saturate at their maximum.
// ----------------------------------------------------------------------------
module luminance_histogram (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// cmd, red, green, blue, bin_index
	input  logic [lhist_pkg::S_DATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// bin_count
	output logic [lhist_pkg::M_DATA_W-1:0]   m_axis_tdata
);
	import lhist_pkg::*;

	q_word_t push;
	q_word_t head;
	logic    q_full;
	logic    pop;

	lhist_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.push          (push),
		.q_full        (q_full)
	);

	lhist_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	lhist_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ----- rtl/core/lhist_checker.sv -----
// ----------------------------------------------------------------------------
// lhist_checker
// Port-level checks of the luminance histogram, bound to the top level.
// ----------------------------------------------------------------------------
module lhist_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tready,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [lhist_pkg::M_DATA_W-1:0]   m_axis_tdata
);

	// stalled result word stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// no result can come out earlier than the pipeline depth after reset
	a_reset_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_axis_tvalid ##1 !m_axis_tvalid ##1 !m_axis_tvalid
			##1 !m_axis_tvalid)
		else $error("result word too early after reset");

	// input backpressure only follows a stalled result side
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> $past(m_axis_tvalid))
		else $error("input stalled without result backpressure");

endmodule

bind luminance_histogram lhist_checker u_lhist_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
